FILE: hdl/alte_pkg.sv
// ============================================================================
// alte_pkg - shared definitions for the array list table engine
// Sizes, request and status codes, and the structs passed between blocks.
// ============================================================================
package alte_pkg;

    localparam int DEPTH = 64;                   // list capacity, 2..64
    localparam int AW    = $clog2(DEPTH);        // entry index width
    localparam int CW    = $clog2(DEPTH + 1);    // fill count width
    localparam int PW    = 7;                    // position / where width
    localparam int VW    = 32;                   // value width

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_UPDATE = 3'd2,
        MODE_SEARCH = 3'd3,
        MODE_MIN    = 3'd4,
        MODE_MAX    = 3'd5,
        MODE_DUMP   = 3'd6
    } alte_mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } alte_status_t;

    // One event a cycle from the walker to the result stage.
    typedef struct packed {
        logic              fin;       // single final result with status
        logic              ent;       // one stored entry read back
        logic              tail;      // scan finished, close out request
        alte_mode_t        op;
        alte_status_t      status;
        logic [AW-1:0]     idx;
        logic              last_ent;
        logic [VW-1:0]     rdata;
        logic [VW-1:0]     key;
    } alte_evt_t;

    typedef struct packed {
        logic [CW-1:0]     used;
        logic              scanning;
    } alte_stat_t;

endpackage

FILE: hdl/alte_ram.sv
// ============================================================================
// alte_ram - generic simple dual port RAM
// One write port, one read port, read data registered.
// ============================================================================
module alte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/alte_walk.sv
// ============================================================================
// alte_walk - request decode, fill count and entry walker
// Owns the entry RAM; issues one read per cycle for scans and shifts.
// ============================================================================
module alte_walk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [2:0]                      mode,
    input  logic [alte_pkg::PW-1:0]         position,
    input  logic signed [alte_pkg::VW-1:0]  value,
    output logic                            busy,
    output alte_pkg::alte_evt_t             evt,
    output alte_pkg::alte_stat_t            stat
);

    typedef enum logic {S_IDLE, S_SCAN} state_t;

    state_t                       state_reg, state_next;
    alte_pkg::alte_mode_t         op_reg, op_next;
    logic [alte_pkg::VW-1:0]      key_reg, key_next;
    logic [alte_pkg::AW-1:0]      ptr_reg, ptr_next;
    logic [alte_pkg::CW-1:0]      used_reg, used_next;
    logic                         rv_reg, rv_next;
    logic                         rl_reg, rl_next;
    logic [alte_pkg::AW-1:0]      ri_reg, ri_next;
    logic                         tail_reg, tail_next;

    logic                         we, re;
    logic [alte_pkg::AW-1:0]      waddr;
    logic [alte_pkg::VW-1:0]      wdata;
    logic [alte_pkg::VW-1:0]      rdata;

    logic                         accept;
    logic                         bad_pos;
    logic [alte_pkg::PW-1:0]      used_ext;
    logic [alte_pkg::AW-1:0]      last_idx;

    alte_ram #(
        .WIDTH (alte_pkg::VW),
        .DEPTH (alte_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    assign busy     = (state_reg != S_IDLE) || rv_reg || tail_reg;
    assign accept   = start && !busy;
    assign used_ext = alte_pkg::PW'(used_reg);
    assign bad_pos  = (position == '0) || (position > used_ext);
    assign last_idx = alte_pkg::AW'(used_reg - alte_pkg::CW'(1));

    assign stat.used     = used_reg;
    assign stat.scanning = (state_reg == S_SCAN);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        ptr_next   = ptr_reg;
        used_next  = used_reg;
        rv_next    = 1'b0;
        rl_next    = 1'b0;
        ri_next    = ri_reg;
        tail_next  = 1'b0;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = used_reg[alte_pkg::AW-1:0];
        wdata      = value;

        evt          = '0;
        evt.op       = op_reg;
        evt.status   = alte_pkg::ST_OK;
        evt.idx      = ri_reg;
        evt.last_ent = rl_reg;
        evt.rdata    = rdata;
        evt.key      = key_reg;

        if (accept)
        begin
            op_next  = alte_pkg::alte_mode_t'(mode);
            key_next = value;
            ptr_next = '0;
            unique case (alte_pkg::alte_mode_t'(mode))
                alte_pkg::MODE_APPEND:
                begin
                    evt.fin = 1'b1;
                    if (used_reg == alte_pkg::FULL_COUNT)
                    begin
                        evt.status = alte_pkg::ST_FULL;
                    end
                    else
                    begin
                        we        = 1'b1;
                        used_next = used_reg + alte_pkg::CW'(1);
                    end
                end
                alte_pkg::MODE_DELETE:
                begin
                    if (bad_pos)
                    begin
                        evt.fin    = 1'b1;
                        evt.status = alte_pkg::ST_BADPOS;
                    end
                    else if (position == used_ext)
                    begin
                        // last entry: nothing to shift
                        evt.fin   = 1'b1;
                        used_next = used_reg - alte_pkg::CW'(1);
                    end
                    else
                    begin
                        ptr_next   = alte_pkg::AW'(position);
                        state_next = S_SCAN;
                    end
                end
                alte_pkg::MODE_UPDATE:
                begin
                    evt.fin = 1'b1;
                    if (bad_pos)
                    begin
                        evt.status = alte_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        we    = 1'b1;
                        waddr = alte_pkg::AW'(position - alte_pkg::PW'(1));
                    end
                end
                alte_pkg::MODE_SEARCH:
                begin
                    if (used_reg == '0)
                    begin
                        evt.fin    = 1'b1;
                        evt.status = alte_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                alte_pkg::MODE_MIN, alte_pkg::MODE_MAX, alte_pkg::MODE_DUMP:
                begin
                    if (used_reg == '0)
                    begin
                        evt.fin    = 1'b1;
                        evt.status = alte_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                default:
                begin
                    evt.fin = 1'b1;
                end
            endcase
        end

        // Issue one read a cycle until the last stored entry.
        if (state_reg == S_SCAN)
        begin
            re       = 1'b1;
            rv_next  = 1'b1;
            ri_next  = ptr_reg;
            rl_next  = (ptr_reg == last_idx);
            ptr_next = ptr_reg + alte_pkg::AW'(1);
            if (ptr_reg == last_idx)
            begin
                state_next = S_IDLE;
            end
        end

        // Read data is back: shift down for delete, else pass it on.
        if (rv_reg)
        begin
            if (op_reg == alte_pkg::MODE_DELETE)
            begin
                we    = 1'b1;
                waddr = ri_reg - alte_pkg::AW'(1);
                wdata = rdata;
                if (rl_reg)
                begin
                    evt.fin   = 1'b1;
                    used_next = used_reg - alte_pkg::CW'(1);
                end
            end
            else
            begin
                evt.ent = 1'b1;
                if (rl_reg && (op_reg != alte_pkg::MODE_DUMP))
                begin
                    tail_next = 1'b1;
                end
            end
        end

        if (tail_reg)
        begin
            evt.tail = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            rv_reg    <= 1'b0;
            rl_reg    <= 1'b0;
            tail_reg  <= 1'b0;
            op_reg    <= alte_pkg::MODE_APPEND;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            rv_reg    <= rv_next;
            rl_reg    <= rl_next;
            tail_reg  <= tail_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        ptr_reg <= ptr_next;
        ri_reg  <= ri_next;
    end

endmodule

FILE: hdl/alte_emit.sv
// ============================================================================
// alte_emit - result stage
// Compares, keeps the running min/max, holds one pending search hit and
// registers the result ports.
// ============================================================================
module alte_emit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  alte_pkg::alte_evt_t             evt,
    output logic                            strobe,
    output logic [2:0]                      status,
    output logic [alte_pkg::PW-1:0]         where,
    output logic signed [alte_pkg::VW-1:0]  data,
    output logic                            last
);

    logic                        strobe_reg, strobe_next;
    alte_pkg::alte_status_t      status_reg, status_next;
    logic [alte_pkg::PW-1:0]     where_reg, where_next;
    logic [alte_pkg::VW-1:0]     data_reg, data_next;
    logic                        last_reg, last_next;
    logic                        pend_reg, pend_next;
    logic [alte_pkg::AW-1:0]     pidx_reg, pidx_next;
    logic [alte_pkg::VW-1:0]     best_reg, best_next;

    logic                        first, take_min, take_max;

    assign first    = (evt.idx == '0);
    assign take_min = $signed(evt.rdata) < $signed(best_reg);
    assign take_max = $signed(evt.rdata) > $signed(best_reg);

    always_comb
    begin
        strobe_next = 1'b0;
        status_next = alte_pkg::ST_OK;
        where_next  = '0;
        data_next   = '0;
        last_next   = 1'b1;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        best_next   = best_reg;

        if (evt.fin)
        begin
            strobe_next = 1'b1;
            status_next = evt.status;
        end
        else if (evt.ent)
        begin
            unique case (evt.op)
                alte_pkg::MODE_SEARCH:
                begin
                    if (evt.rdata == evt.key)
                    begin
                        // release the previous hit; it is not the final one
                        if (pend_reg)
                        begin
                            strobe_next = 1'b1;
                            where_next  = alte_pkg::PW'(pidx_reg) + alte_pkg::PW'(1);
                            last_next   = 1'b0;
                        end
                        pend_next = 1'b1;
                        pidx_next = evt.idx;
                    end
                end
                alte_pkg::MODE_MIN:
                begin
                    if (first || take_min)
                    begin
                        best_next = evt.rdata;
                    end
                end
                alte_pkg::MODE_MAX:
                begin
                    if (first || take_max)
                    begin
                        best_next = evt.rdata;
                    end
                end
                alte_pkg::MODE_DUMP:
                begin
                    strobe_next = 1'b1;
                    where_next  = alte_pkg::PW'(evt.idx) + alte_pkg::PW'(1);
                    data_next   = evt.rdata;
                    last_next   = evt.last_ent;
                end
                default:
                begin
                end
            endcase
        end
        else if (evt.tail)
        begin
            strobe_next = 1'b1;
            if (evt.op == alte_pkg::MODE_SEARCH)
            begin
                pend_next = 1'b0;
                if (pend_reg)
                begin
                    where_next = alte_pkg::PW'(pidx_reg) + alte_pkg::PW'(1);
                end
                else
                begin
                    status_next = alte_pkg::ST_NOTFOUND;
                end
            end
            else
            begin
                data_next = best_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        where_reg  <= where_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
        pidx_reg   <= pidx_next;
        best_reg   <= best_next;
    end

    assign strobe = strobe_reg;
    assign status = status_reg;
    assign where  = where_reg;
    assign data   = data_reg;
    assign last   = last_reg;

endmodule

FILE: hdl/array_list_table_engine.sv
// ============================================================================
// array_list_table_engine - packed list of signed words with search and scan
// Append, delete, update, search, minimum, maximum and dump on a RAM list.
// ============================================================================
// Usage:
//   A request transaction is taken at a rising edge with start high and busy
//   low; mode, position and value are sampled there. Results leave on
//   status/where/data/last, each valid for the single cycle that strobe is
//   high; last marks the final result of a request. The receiver cannot
//   stall, so results are never held back.
//   Append, update, mode 7, a delete of the last entry and every error
//   case but a search miss on a non-empty list finish in the accept cycle,
//   with the result registered into the next cycle. Delete from position p
//   walks the later entries through the RAM read port. Dump streams one
//   entry per cycle; search, min and max issue one RAM read per cycle.
//   Busy stays high until the walk ends, and no request is taken while
//   busy is high.
//   Reset clears the fill count and control state, not the entry RAM;
//   it needs no clearing pass: entries at or above the count are never read.
// ============================================================================
module array_list_table_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      mode,
    input  logic [alte_pkg::PW-1:0]         position,
    input  logic signed [alte_pkg::VW-1:0]  value,
    output logic                            strobe,
    output logic [2:0]                      status,
    output logic [alte_pkg::PW-1:0]         where,
    output logic signed [alte_pkg::VW-1:0]  data,
    output logic                            last
);

    alte_pkg::alte_evt_t   evt;
    alte_pkg::alte_stat_t  stat;

    // Decode requests, keep the count and drive the entry RAM.
    alte_walk u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .mode     (mode),
        .position (position),
        .value    (value),
        .busy     (busy),
        .evt      (evt),
        .stat     (stat)
    );

    // Turn walker events into registered result transactions.
    alte_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .evt    (evt),
        .strobe (strobe),
        .status (status),
        .where  (where),
        .data   (data),
        .last   (last)
    );

    // Every request either keeps the block busy or answers next cycle.
    a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || strobe))
        else $error("accepted request produced no activity");

    // Fill count never exceeds capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.used <= alte_pkg::FULL_COUNT)
        else $error("fill count above capacity");

    // Full is reported only when the list really was full.
    a_full_real: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == alte_pkg::ST_FULL)) |->
            ($past(stat.used) == alte_pkg::FULL_COUNT))
        else $error("full reported with room left");

    // Any error status is the closing result of its request.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status != alte_pkg::ST_OK)) |-> last)
        else $error("error result not marked last");

endmodule

FILE: tb/tb_array_list_table_engine.sv
// ============================================================================
// tb_array_list_table_engine - self-checking bench for the list engine
// Runs a table of directed requests and then a long random mix of requests.
// A behavioral copy of the list predicts the reply stream of each request,
// and every strobed reply is compared field by field with the oldest one due.
// ============================================================================
module tb_array_list_table_engine;

    timeunit 1ns;
    timeprecision 1ps;

    import alte_pkg::*;

    // Mode 7 has no name in the package; it does nothing and replies OK.
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam int RAND_ITEMS   = 105;     // random requests after the table
    localparam int MIX_BEFORE   = 20;      // mixed requests before the fill burst
    localparam int OVERFLOW_ADD = 3;       // appends tried on a full list
    localparam int PAUSE_AT     = 95;      // random request that waits for drain
    localparam int CALM_FROM    = 40;      // no sender gaps from here ...
    localparam int CALM_TO      = 70;      // ... up to here
    localparam int TAIL_CYCLES  = 80;      // idle cycles watched after the drain
    localparam int LIMIT_CYCLES = 100_000;

    // One reply of the engine, in port order.
    typedef struct packed {
        alte_status_t   status;
        logic [PW-1:0]  where;
        logic [VW-1:0]  data;
        logic           last;
    } list_reply_t;

    // One directed request. Where 'typed' is set the single reply is given
    // here (where = 0, last = 1); otherwise the list copy works it out.
    typedef struct packed {
        logic [2:0]     op;
        logic [PW-1:0]  pos;
        logic [VW-1:0]  val;
        logic           typed;
        alte_status_t   st;
        logic [VW-1:0]  dat;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // empty list: every scan reports empty, search finds nothing, positions are bad
        '{MODE_MIN,    7'd0,   32'd0,         1'b1, ST_EMPTY,    32'd0},
        '{MODE_MAX,    7'd9,   32'd0,         1'b1, ST_EMPTY,    32'd0},
        '{MODE_DUMP,   7'd0,   32'hFFFF_FFFF, 1'b1, ST_EMPTY,    32'd0},
        '{MODE_SEARCH, 7'd0,   32'd5,         1'b1, ST_NOTFOUND, 32'd0},
        '{MODE_DELETE, 7'd1,   32'd0,         1'b1, ST_BADPOS,   32'd0},
        '{MODE_UPDATE, 7'd0,   32'd1,         1'b1, ST_BADPOS,   32'd0},
        // build [0, most negative, -1, most positive, 0]
        '{MODE_APPEND, 7'd0,   32'd0,         1'b1, ST_OK,       32'd0},
        '{MODE_APPEND, 7'd127, 32'h8000_0000, 1'b1, ST_OK,       32'd0},
        '{MODE_APPEND, 7'd0,   32'hFFFF_FFFF, 1'b1, ST_OK,       32'd0},
        '{MODE_APPEND, 7'd64,  32'h7FFF_FFFF, 1'b1, ST_OK,       32'd0},
        '{MODE_APPEND, 7'd0,   32'd0,         1'b1, ST_OK,       32'd0},
        '{MODE_MIN,    7'd0,   32'd0,         1'b1, ST_OK,       32'h8000_0000},
        '{MODE_MAX,    7'd0,   32'd0,         1'b1, ST_OK,       32'h7FFF_FFFF},
        // two matches, then a key with none and a position that is ignored, then a dump
        '{MODE_SEARCH, 7'd3,   32'd0,         1'b0, ST_OK,       32'd0},
        '{MODE_SEARCH, 7'd127, 32'h1234_5678, 1'b1, ST_NOTFOUND, 32'd0},
        '{MODE_DUMP,   7'd0,   32'd0,         1'b0, ST_OK,       32'd0},
        // one past the count and the top position are out of range; the last entry updates
        '{MODE_UPDATE, 7'd6,   32'd7,         1'b1, ST_BADPOS,   32'd0},
        '{MODE_UPDATE, 7'd127, 32'd7,         1'b1, ST_BADPOS,   32'd0},
        '{MODE_UPDATE, 7'd5,   32'h5555_5555, 1'b1, ST_OK,       32'd0},
        // drop the last entry, then the first, then miss, then mode 7
        '{MODE_DELETE, 7'd5,   32'd0,         1'b1, ST_OK,       32'd0},
        '{MODE_DELETE, 7'd1,   32'hAAAA_AAAA, 1'b1, ST_OK,       32'd0},
        '{MODE_DELETE, 7'd4,   32'd0,         1'b1, ST_BADPOS,   32'd0},
        '{MODE_UNUSED, 7'd127, 32'hFFFF_FFFF, 1'b1, ST_OK,       32'd0},
        // the maximum now sits in the final entry
        '{MODE_MAX,    7'd0,   32'd0,         1'b1, ST_OK,       32'h7FFF_FFFF},
        '{MODE_DUMP,   7'd0,   32'd0,         1'b0, ST_OK,       32'd0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [2:0]             mode;
    logic [PW-1:0]          position;
    logic signed [VW-1:0]   value;
    logic                   strobe;
    logic [2:0]             status;
    logic [PW-1:0]          where;
    logic signed [VW-1:0]   data;
    logic                   last;

    // Copy of the list held by the engine, and the replies still owed.
    logic signed [VW-1:0]   list_mem [DEPTH];
    int                     list_fill;
    list_reply_t            replies_due [$];
    int                     fault_count;

    array_list_table_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .position (position),
        .value    (value),
        .strobe   (strobe),
        .status   (status),
        .where    (where),
        .data     (data),
        .last     (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the engine hangs or drops a reply.
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

    // Queue one reply unless the caller supplies its own.
    function automatic void owe_reply(input bit keep, input alte_status_t st,
                                      input logic [PW-1:0] wh, input logic [VW-1:0] dat,
                                      input logic lst);
        list_reply_t r;
        r = '{st, wh, dat, lst};
        if (keep)
            replies_due.push_back(r);
    endfunction

    // Apply one accepted request to the list copy and queue its replies.
    function automatic void apply_list_op(input logic [2:0] op, input logic [PW-1:0] pos,
                                          input logic signed [VW-1:0] val, input bit keep);
        int hits;
        int seen;
        logic signed [VW-1:0] best;
        hits = 0;
        seen = 0;
        case (op)
            MODE_APPEND:
            begin
                if (list_fill >= DEPTH)
                    owe_reply(keep, ST_FULL, '0, '0, 1'b1);
                else
                begin
                    list_mem[list_fill] = val;
                    list_fill++;
                    owe_reply(keep, ST_OK, '0, '0, 1'b1);
                end
            end
            MODE_DELETE, MODE_UPDATE:
            begin
                if (pos == 0 || pos > list_fill)
                    owe_reply(keep, ST_BADPOS, '0, '0, 1'b1);
                else
                begin
                    if (op == MODE_UPDATE)
                        list_mem[pos - 1] = val;
                    else
                    begin
                        // close the gap: later entries move down one slot
                        for (int i = pos - 1; i + 1 < list_fill; i++)
                            list_mem[i] = list_mem[i + 1];
                        list_fill--;
                    end
                    owe_reply(keep, ST_OK, '0, '0, 1'b1);
                end
            end
            MODE_SEARCH:
            begin
                // count first so the final match can carry last
                for (int i = 0; i < list_fill; i++)
                    if (list_mem[i] == val)
                        hits++;
                if (hits == 0)
                    owe_reply(keep, ST_NOTFOUND, '0, '0, 1'b1);
                for (int i = 0; i < list_fill; i++)
                begin
                    if (list_mem[i] == val)
                    begin
                        seen++;
                        owe_reply(keep, ST_OK, PW'(i + 1), '0, seen == hits);
                    end
                end
            end
            MODE_MIN, MODE_MAX:
            begin
                if (list_fill == 0)
                    owe_reply(keep, ST_EMPTY, '0, '0, 1'b1);
                else
                begin
                    // signed scan over every stored entry, the final one included
                    best = list_mem[0];
                    for (int i = 1; i < list_fill; i++)
                        if (op == MODE_MIN ? (list_mem[i] < best) : (list_mem[i] > best))
                            best = list_mem[i];
                    owe_reply(keep, ST_OK, '0, best, 1'b1);
                end
            end
            MODE_DUMP:
            begin
                if (list_fill == 0)
                    owe_reply(keep, ST_EMPTY, '0, '0, 1'b1);
                for (int i = 0; i < list_fill; i++)
                    owe_reply(keep, ST_OK, PW'(i + 1), list_mem[i], i + 1 == list_fill);
            end
            default:
                owe_reply(keep, ST_OK, '0, '0, 1'b1);
        endcase
    endfunction

    // Present one request after 'gap' idle cycles and hold it until taken.
    // Inputs change on the falling edge; acceptance is judged on busy as it
    // stood just before the rising edge.
    task automatic send_request(input logic [2:0] op, input logic [PW-1:0] pos,
                                input logic [VW-1:0] val, input int gap,
                                input bit typed, input list_reply_t typed_reply);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        mode     <= op;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (busy);
        apply_list_op(op, pos, val, !typed);
        if (typed)
            replies_due.push_back(typed_reply);
    endtask

    // Operand values: extremes, a small pool that makes duplicates, and noise.
    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return VW'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // Mostly a position that hits the list, now and then any 7-bit value.
    function automatic logic [PW-1:0] pick_position();
        if (list_fill > 0 && $urandom_range(0, 99) < 80)
            return PW'($urandom_range(1, list_fill));
        return PW'($urandom_range(0, 127));
    endfunction

    // Check every strobed reply against the oldest one owed.
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n && strobe)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: reply with none due: status=%0d where=%0d data=%h last=%b",
                         $time, status, where, data, last);
                fault_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if ({status, where, data, last} !== want)
                begin
                    $display("%0t: reply mismatch: expected status=%0d where=%0d data=%h last=%b",
                             $time, want.status, want.where, want.data, want.last);
                    $display("%0t:                 actual   status=%0d where=%0d data=%h last=%b",
                             $time, status, where, data, last);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        int          gap;
        int          pick;
        int          overflow_tries;
        logic [2:0]  op;
        logic [PW-1:0] pos;
        logic [VW-1:0] val;
        dir_row_t    row;

        start          = 1'b0;
        mode           = MODE_APPEND;
        position       = '0;
        value          = '0;
        rst_n          = 1'b0;
        list_fill      = 0;
        fault_count    = 0;
        overflow_tries = 0;

        // Hold reset, once, then release on a falling edge.
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: empty-list errors, extremes, bad positions, mode 7.
        for (int k = 0; k < DIR_ROWS; k++)
        begin
            row = DIR_TABLE[k];
            gap = ($urandom_range(0, 99) < 33) ? $urandom_range(1, 3) : 0;
            send_request(row.op, row.pos, row.val, gap, row.typed,
                         '{row.st, 7'd0, row.dat, 1'b1});
        end

        // Random mix. After a first stretch, append until the list is full
        // and then a few more to hit the full case, then mix again.
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            // Sender pause: drop start and hold off until every owed reply is back.
            if (n == PAUSE_AT)
            begin
                @(negedge clk);
                start <= 1'b0;
                while (replies_due.size() != 0)
                    @(posedge clk);
            end

            pos = pick_position();
            val = pick_value();
            if (n >= MIX_BEFORE && overflow_tries < OVERFLOW_ADD)
            begin
                op = MODE_APPEND;
                if (list_fill == DEPTH)
                    overflow_tries++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 28)      op = MODE_APPEND;
                else if (pick < 43) op = MODE_DELETE;
                else if (pick < 56) op = MODE_UPDATE;
                else if (pick < 70) op = MODE_SEARCH;
                else if (pick < 78) op = MODE_MIN;
                else if (pick < 86) op = MODE_MAX;
                else if (pick < 96) op = MODE_DUMP;
                else                op = MODE_UNUSED;
                // Search keys mostly taken from the list so matches occur.
                if (op == MODE_SEARCH && list_fill > 0 && $urandom_range(0, 99) < 60)
                    val = list_mem[$urandom_range(0, list_fill - 1)];
            end

            if (n >= CALM_FROM && n < CALM_TO)
                gap = 0;
            else
                gap = ($urandom_range(0, 99) < 33) ? $urandom_range(1, 4) : 0;
            send_request(op, pos, val, gap, 1'b0, '0);
        end

        // Drop start, drain the replies, then watch for strays.
        @(negedge clk);
        start <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/alte_pkg.sv
hdl/alte_ram.sv
hdl/alte_walk.sv
hdl/alte_emit.sv
hdl/array_list_table_engine.sv
tb/tb_array_list_table_engine.sv
